[rtl/core/lod_node_refine_select_unit_assert.svh]
// assertion macros for the lod node refine select block
`ifndef LOD_NODE_REFINE_SELECT_UNIT_ASSERT_SVH
`define LOD_NODE_REFINE_SELECT_UNIT_ASSERT_SVH

// clocked assertion, disabled while reset is low
`define LNRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lnrs assertion failed");

// clocked assertion that also holds through reset
`define LNRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lnrs assertion failed");

`endif

[rtl/core/lnrs_pkg.sv]
// ----------------------------------------------------------------------------
// lnrs_pkg
// shared types and constants of the lod node refine select block
// ----------------------------------------------------------------------------
package lnrs_pkg;

  localparam int unsigned LNRS_QDEPTH = 2;
  localparam int unsigned LNRS_ROOT_W = 36;
  localparam int unsigned LNRS_SUM_W  = 68;
  localparam int unsigned LNRS_DIV_W  = 20;

  typedef enum logic [1:0] {
    ACT_CULL    = 2'd0,
    ACT_SHOW    = 2'd1,
    ACT_DESCEND = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_EYE_X   = 3'd0,
    REG_EYE_Y   = 3'd1,
    REG_EYE_Z   = 3'd2,
    REG_FOCAL   = 3'd3,
    REG_CULL    = 3'd4,
    REG_DESCEND = 3'd5,
    REG_HYST    = 3'd6,
    REG_BUDGET  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic [19:0]        focal_px;
    logic [19:0]        cull_px;
    logic [19:0]        descend_px;
    logic [11:0]        hysteresis_scale;
    logic [31:0]        frame_budget;
  } cfg_t;

  // classified node: extents, nearest-point offsets, flags, point count and frame start
  typedef struct packed {
    logic [32:0] ext_x;
    logic [32:0] ext_y;
    logic [32:0] ext_z;
    logic [32:0] near_x;
    logic [32:0] near_y;
    logic [32:0] near_z;
    logic        is_leaf;
    logic        was_descended;
    logic [23:0] pts;
    logic        frame_start;
  } job_t;

endpackage

[rtl/core/lnrs_if.sv]
// ----------------------------------------------------------------------------
// lnrs_if
// request channels of the block: node requests in, results out
// ----------------------------------------------------------------------------
interface lnrs_node_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic               is_leaf;
  logic               was_descended;
  logic [23:0]        resident_points;
  logic               frame_start;

  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, is_leaf, was_descended, resident_points, frame_start,
                  input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, is_leaf, was_descended, resident_points, frame_start,
                output ready);
endinterface

interface lnrs_res_if;
  logic        valid;
  logic        ready;
  logic [19:0] screen_size;
  logic [1:0]  action;
  logic [31:0] points_used;

  modport source (output valid, screen_size, action, points_used, input ready);
  modport sink (input valid, screen_size, action, points_used, output ready);
endinterface

[rtl/core/lod_node_refine_select_unit.sv]
// path: queue, squares, root units, multiply, divide and decision; the divide is skipped when the size saturates
// the back end works one node at a time, mostly in the 36-step root units and 20-step divider
// the two-entry queue takes up to two further nodes while one is worked
// reset: asynchronous, active low; registers return to defaults, frame counter to zero
// ----------------------------------------------------------------------------
// lod_node_refine_select_unit
// screen-space size level-of-detail selection for one tree node per request
// ----------------------------------------------------------------------------
module lod_node_refine_select_unit import lnrs_pkg::*; #(
  parameter int unsigned QueueDepth = LNRS_QDEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  lnrs_node_if.sink   node_i,
  lnrs_res_if.source  res_o
);

  cfg_t cfg_q;
  logic q_full, q_push, q_valid, q_pop;
  job_t q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eye_x            <= '0;
      cfg_q.eye_y            <= '0;
      cfg_q.eye_z            <= '0;
      cfg_q.focal_px         <= 20'd16384;
      cfg_q.cull_px          <= 20'd32;
      cfg_q.descend_px       <= 20'd1600;
      cfg_q.hysteresis_scale <= 12'd256;
      cfg_q.frame_budget     <= 32'd2000000;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_EYE_X:   cfg_q.eye_x            <= cfg_wdata_i;
        REG_EYE_Y:   cfg_q.eye_y            <= cfg_wdata_i;
        REG_EYE_Z:   cfg_q.eye_z            <= cfg_wdata_i;
        REG_FOCAL:   cfg_q.focal_px         <= cfg_wdata_i[19:0];
        REG_CULL:    cfg_q.cull_px          <= cfg_wdata_i[19:0];
        REG_DESCEND: cfg_q.descend_px       <= cfg_wdata_i[19:0];
        REG_HYST:    cfg_q.hysteresis_scale <= cfg_wdata_i[11:0];
        REG_BUDGET:  cfg_q.frame_budget     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lnrs_front u_front (
    .node_i, .cfg_i(cfg_q), .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_wdata)
  );

  lnrs_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_wdata), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_rdata)
  );

  lnrs_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .job_valid_i(q_valid), .job_i(q_rdata),
    .job_pop_o(q_pop), .res_o
  );

endmodule

[rtl/core/lnrs_front.sv]
// ----------------------------------------------------------------------------
// lnrs_front
// accepts node requests and works out box extents and eye offsets
// ----------------------------------------------------------------------------
module lnrs_front import lnrs_pkg::*; (
  lnrs_node_if.sink node_i,
  input  cfg_t      cfg_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output job_t      q_data_o
);

  // |a - b| over 33 bits
  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  // distance from eye to the nearest coordinate of [lo, hi]
  function automatic logic [32:0] near_off(input logic signed [31:0] e,
                                           input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
    if (e < lo) return abs_diff(lo, e);
    else if (e > hi) return abs_diff(e, hi);
    else return 33'd0;
  endfunction

  assign node_i.ready = !q_full_i;
  assign q_push_o     = node_i.valid && !q_full_i;

  // classify into a job for the back end
  always_comb begin
    q_data_o.ext_x         = abs_diff(node_i.box_max_x, node_i.box_min_x);
    q_data_o.ext_y         = abs_diff(node_i.box_max_y, node_i.box_min_y);
    q_data_o.ext_z         = abs_diff(node_i.box_max_z, node_i.box_min_z);
    q_data_o.near_x        = near_off(cfg_i.eye_x, node_i.box_min_x, node_i.box_max_x);
    q_data_o.near_y        = near_off(cfg_i.eye_y, node_i.box_min_y, node_i.box_max_y);
    q_data_o.near_z        = near_off(cfg_i.eye_z, node_i.box_min_z, node_i.box_max_z);
    q_data_o.is_leaf       = node_i.is_leaf;
    q_data_o.was_descended = node_i.was_descended;
    q_data_o.pts           = node_i.resident_points;
    q_data_o.frame_start   = node_i.frame_start;
  end

endmodule

[rtl/core/lnrs_queue.sv]
// ----------------------------------------------------------------------------
// lnrs_queue
// short job queue between front and back end
// ----------------------------------------------------------------------------
module lnrs_queue import lnrs_pkg::*; #(
  parameter int unsigned Depth = LNRS_QDEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[rtl/core/lnrs_isqrt.sv]
// ----------------------------------------------------------------------------
// lnrs_isqrt
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module lnrs_isqrt import lnrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [LNRS_SUM_W-1:0]   op_i,
  output logic                    done_o,
  output logic [LNRS_ROOT_W-1:0]  root_o
);

  localparam int unsigned OpW  = 2 * LNRS_ROOT_W;
  localparam int unsigned RemW = LNRS_ROOT_W + 2;
  localparam int unsigned CntW = $clog2(LNRS_ROOT_W);

  logic [OpW-1:0]         op_q;
  logic [RemW-1:0]        rem_q;
  logic [LNRS_ROOT_W-1:0] root_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, done_q;
  logic [RemW+1:0]        rem_sh, trial, diff;
  logic                   take;

  assign rem_sh = {rem_q, op_q[OpW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;
  assign done_o = done_q;
  assign root_o = root_q;

  // iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(LNRS_ROOT_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(LNRS_ROOT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= OpW'(op_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= op_q << 2;
      rem_q  <= take ? diff[RemW-1:0] : rem_sh[RemW-1:0];
      root_q <= {root_q[LNRS_ROOT_W-2:0], take};
    end
  end

endmodule

[rtl/core/lnrs_back.sv]
// ----------------------------------------------------------------------------
// lnrs_back
// norms, projection, divide and refine decision for one job at a time
// ----------------------------------------------------------------------------
module lnrs_back import lnrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  lnrs_res_if.source       res_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQR, ST_ROOT, ST_MUL, ST_DIVI, ST_DIV, ST_DEC
  } state_e;

  localparam int unsigned ProdW = LNRS_ROOT_W + 20;

  state_e                 state_q;
  job_t                   job_q;
  logic [2:0]             cnt3_q;
  logic [4:0]             cnt5_q;
  logic [LNRS_SUM_W-1:0]  acc_diag_q, acc_dist_q;
  logic                   start_q;
  logic [ProdW-1:0]       prod_q;
  logic [31:0]            thr_q;
  logic [LNRS_ROOT_W-1:0] dist_q, rem_q;
  logic [19:0]            lo_q, quo_q, size_q;
  logic [31:0]            fp_q;
  logic                   res_valid_q;
  logic [19:0]            res_size_q;
  action_e                res_act_q;
  logic [31:0]            res_pts_q;

  logic [32:0]            sq_op;
  logic [65:0]            sq;
  logic                   diag_done, dist_done;
  logic [LNRS_ROOT_W-1:0] diag_root, dist_root;
  logic [LNRS_ROOT_W:0]   div_sh, div_sub;
  logic                   div_take;
  logic                   slot_free;
  logic                   res_fire;
  logic [31:0]            fp_base;
  logic [32:0]            fp_sum;
  logic [31:0]            fp_new;
  logic                   over;

  // squarer operand select
  always_comb begin
    case (cnt3_q)
      3'd0:    sq_op = job_q.ext_x;
      3'd1:    sq_op = job_q.ext_y;
      3'd2:    sq_op = job_q.ext_z;
      3'd3:    sq_op = job_q.near_x;
      3'd4:    sq_op = job_q.near_y;
      default: sq_op = job_q.near_z;
    endcase
  end
  assign sq = sq_op * sq_op;

  // two root units run side by side
  lnrs_isqrt u_root_diag (
    .clk_i, .rst_ni, .start_i(start_q), .op_i(acc_diag_q),
    .done_o(diag_done), .root_o(diag_root)
  );
  lnrs_isqrt u_root_dist (
    .clk_i, .rst_ni, .start_i(start_q), .op_i(acc_dist_q),
    .done_o(dist_done), .root_o(dist_root)
  );

  // divider step
  assign div_sh   = {rem_q, lo_q[19]};
  assign div_take = (div_sh >= {1'b0, dist_q});
  assign div_sub  = div_sh - {1'b0, dist_q};

  // frame counter and decision
  assign slot_free = !res_valid_q || res_o.ready;
  assign res_fire  = (state_q == ST_DEC) && slot_free;
  assign fp_base   = job_q.frame_start ? 32'd0 : fp_q;
  assign fp_sum    = {1'b0, fp_base} + 33'(job_q.pts);
  assign fp_new    = fp_sum[32] ? 32'hFFFF_FFFF : fp_sum[31:0];
  assign over      = job_q.was_descended ? ({size_q, 8'd0} > thr_q)
                                         : (size_q > cfg_i.descend_px);

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt3_q      <= '0;
      cnt5_q      <= '0;
      start_q     <= 1'b0;
      fp_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      start_q <= (state_q == ST_SQR) && (cnt3_q == 3'd5);
      if (res_valid_q && res_o.ready && !res_fire) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q      <= job_i;
            cnt3_q     <= '0;
            acc_diag_q <= '0;
            acc_dist_q <= '0;
            state_q    <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (cnt3_q < 3'd3) acc_diag_q <= acc_diag_q + LNRS_SUM_W'(sq);
          else acc_dist_q <= acc_dist_q + LNRS_SUM_W'(sq);
          cnt3_q <= cnt3_q + 1'b1;
          if (cnt3_q == 3'd5) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (diag_done && dist_done) state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= diag_root * cfg_i.focal_px;
          thr_q   <= cfg_i.descend_px * cfg_i.hysteresis_scale;
          dist_q  <= (dist_root == '0) ? LNRS_ROOT_W'(1) : dist_root;
          state_q <= ST_DIVI;
        end
        ST_DIVI: begin
          if (prod_q >= {dist_q, 20'd0}) begin
            size_q  <= '1;
            state_q <= ST_DEC;
          end else begin
            rem_q   <= prod_q[ProdW-1:LNRS_DIV_W];
            lo_q    <= prod_q[LNRS_DIV_W-1:0];
            quo_q   <= '0;
            cnt5_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= div_take ? div_sub[LNRS_ROOT_W-1:0] : div_sh[LNRS_ROOT_W-1:0];
          lo_q   <= lo_q << 1;
          quo_q  <= {quo_q[18:0], div_take};
          cnt5_q <= cnt5_q + 1'b1;
          if (cnt5_q == 5'(LNRS_DIV_W - 1)) begin
            size_q  <= {quo_q[18:0], div_take};
            state_q <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_size_q  <= size_q;
            if (size_q < cfg_i.cull_px) begin
              fp_q      <= fp_base;
              res_pts_q <= fp_base;
              res_act_q <= ACT_CULL;
            end else begin
              fp_q      <= fp_new;
              res_pts_q <= fp_new;
              res_act_q <= (!job_q.is_leaf && (fp_new < cfg_i.frame_budget) && over)
                           ? ACT_DESCEND : ACT_SHOW;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.screen_size = res_size_q;
  assign res_o.action      = res_act_q;
  assign res_o.points_used = res_pts_q;

endmodule

[rtl/core/lnrs_checker.sv]
// ----------------------------------------------------------------------------
// lnrs_checker
// port-level checks of the result channel
// ----------------------------------------------------------------------------
`include "lod_node_refine_select_unit_assert.svh"

module lnrs_checker import lnrs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [19:0] res_size_i,
  input logic [1:0]  res_action_i,
  input logic [31:0] res_points_i
);

  logic [53:0] res_all;
  logic        act_ok;

  // result contents and legal action codes
  assign res_all = {res_size_i, res_action_i, res_points_i};
  assign act_ok  = (res_action_i == ACT_CULL) || (res_action_i == ACT_SHOW) ||
                   (res_action_i == ACT_DESCEND);

  // a stalled result keeps its contents
  `LNRS_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_all))

  // only the three action codes appear
  `LNRS_ASSERT_ALWAYS(a_act_legal, clk_i, !res_valid_i || act_ok)

  // descending needs a size above a threshold, so never zero
  `LNRS_ASSERT(a_desc_size, clk_i, rst_ni, res_valid_i && res_action_i == ACT_DESCEND |-> res_size_i != 20'd0)

endmodule

bind lod_node_refine_select_unit lnrs_checker u_lnrs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .res_valid_i(res_o.valid), .res_ready_i(res_o.ready),
  .res_size_i(res_o.screen_size), .res_action_i(res_o.action),
  .res_points_i(res_o.points_used)
);
